// ===== rtl/blx_pkg.sv =====
// ----------------------------------------------------------------------------
// blx_pkg: shared types, constants and helpers of the layer expansion blit
// Register indexes, the per-byte job passed from front to back, dimension
// clamping, layer centring and colour rounding.
// ----------------------------------------------------------------------------
package blx_pkg;

	localparam int MaxDim = 1024;
	localparam int DimW   = 11;
	localparam int XW     = 10;
	localparam int IdxW   = 20;
	localparam int Lanes  = 8;
	localparam int LaneW  = 3;
	localparam int LevelW = 16;
	localparam int ChanW  = 8;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_FRAME_WIDTH  = 3'd0;
	localparam cfg_idx_t CFG_FRAME_HEIGHT = 3'd1;
	localparam cfg_idx_t CFG_LAYER_WIDTH  = 3'd2;
	localparam cfg_idx_t CFG_LAYER_HEIGHT = 3'd3;
	localparam cfg_idx_t CFG_RED_LEVEL    = 3'd4;
	localparam cfg_idx_t CFG_GREEN_LEVEL  = 3'd5;
	localparam cfg_idx_t CFG_BLUE_LEVEL   = 3'd6;

	// Clamped frame and layer dimensions.
	typedef struct packed {
		logic [DimW-1:0] frame_width;
		logic [DimW-1:0] frame_height;
		logic [DimW-1:0] layer_width;
		logic [DimW-1:0] layer_height;
	} dims_t;

	// One byte's worth of pixel writes: which lanes write, the row start
	// index and the frame column of each lane.
	typedef struct packed {
		logic [Lanes-1:0]         mask;
		logic [IdxW-1:0]          row_base;
		logic [Lanes-1:0][XW-1:0] xcol;
	} job_t;

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
		return (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
	endfunction

	// (level*255 + 32767) / 65535, division by 65535 done as
	// (v + (v >> 16) + 1) >> 16, exact for the range of v here.
	function automatic logic [ChanW-1:0] round_level(input logic [LevelW-1:0] lvl);
		logic [23:0] v;
		logic [24:0] s;
		v = ({8'd0, lvl} << 8) - {8'd0, lvl} + 24'd32767;
		s = {1'b0, v} + {17'd0, v[23:16]} + 25'd1;
		return s[23:16];
	endfunction

	// (2*t - lsize + fsize) / 2 with truncation toward zero.
	function automatic logic signed [11:0] centre(input logic [DimW-1:0] t,
		input logic [DimW-1:0] lsize, input logic [DimW-1:0] fsize);
		logic signed [12:0] num;
		logic signed [12:0] half;
		num  = $signed({1'b0, t, 1'b0}) - $signed({2'b00, lsize})
			+ $signed({2'b00, fsize});
		if (num[12]) begin
			half = (num + 13'sd1) >>> 1;
		end else begin
			half = num >>> 1;
		end
		return half[11:0];
	endfunction

	// Coordinate lies inside [0, size).
	function automatic logic in_range(input logic signed [11:0] c,
		input logic [DimW-1:0] size);
		return !c[11] && (c[10:0] < size);
	endfunction

endpackage

// ===== rtl/blx_front.sv =====
// ----------------------------------------------------------------------------
// blx_front: byte intake and classification
// Tracks layer column and row, works out which bits of a byte give in-frame
// writes and their frame coordinates, and queues a job for the back end.
// ----------------------------------------------------------------------------
module blx_front (
	input  logic                clk,
	input  logic                arst_n,
	input  blx_pkg::dims_t      dims,
	input  logic                restart,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          bitmap_byte,
	output logic                push,
	output blx_pkg::job_t       job,
	input  logic                full
);

	logic [blx_pkg::XW-1:0]   col_base_q;
	logic [blx_pkg::DimW-1:0] row_q;
	logic                     accept;
	logic                     active;
	logic signed [11:0]       ypos;
	logic                     y_ok;
	logic [20:0]              row_prod;
	logic [blx_pkg::DimW-1:0] col_next;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign active   = row_q < dims.layer_height;

	assign ypos     = blx_pkg::centre(row_q, dims.layer_height, dims.frame_height);
	assign y_ok     = blx_pkg::in_range(ypos, dims.frame_height);
	assign row_prod = {11'd0, ypos[9:0]} * {10'd0, dims.frame_width};

	always_comb begin
		logic [blx_pkg::DimW-1:0] col;
		logic signed [11:0]       xpos;
		job.row_base = row_prod[blx_pkg::IdxW-1:0];
		for (int k = 0; k < blx_pkg::Lanes; k++) begin
			col = {1'b0, col_base_q} + blx_pkg::DimW'(k);
			xpos = blx_pkg::centre(col, dims.layer_width, dims.frame_width);
			job.mask[k] = bitmap_byte[k] && (col < dims.layer_width) && y_ok
				&& blx_pkg::in_range(xpos, dims.frame_width);
			job.xcol[k] = xpos[blx_pkg::XW-1:0];
		end
	end

	assign push     = accept && active && (|job.mask);
	assign col_next = {1'b0, col_base_q} + blx_pkg::DimW'(blx_pkg::Lanes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_base_q <= '0;
			row_q      <= '0;
		end else if (restart) begin
			col_base_q <= '0;
			row_q      <= '0;
		end else if (accept && active) begin
			if (col_next >= dims.layer_width) begin
				col_base_q <= '0;
				row_q      <= row_q + 11'd1;
			end else begin
				col_base_q <= col_next[blx_pkg::XW-1:0];
			end
		end
	end

endmodule

// ===== rtl/blx_fifo.sv =====
// ----------------------------------------------------------------------------
// blx_fifo: two-entry job queue
// Decouples byte intake from pixel emission.
// ----------------------------------------------------------------------------
module blx_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  blx_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output blx_pkg::job_t rd_job,
	output logic          empty
);

	blx_pkg::job_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full   = count_q == 2'd2;
	assign empty  = count_q == 2'd0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/blx_back.sv =====
// ----------------------------------------------------------------------------
// blx_back: pixel write emission
// Walks the set lanes of the current job lowest first, one write per cycle
// while the output is not stalled, into a registered output beat.
// ----------------------------------------------------------------------------
module blx_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  blx_pkg::job_t           head,
	input  logic                    empty,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [blx_pkg::IdxW-1:0] pixel_index,
	output logic                    last_of_byte
);

	blx_pkg::job_t                cur_q;
	logic [blx_pkg::Lanes-1:0]    rem_q;
	logic                         out_valid_q;
	logic [blx_pkg::IdxW-1:0]     index_q;
	logic                         last_q;
	logic                         busy;
	logic                         adv;
	logic                         fire;
	logic [blx_pkg::LaneW-1:0]    sel;
	logic [blx_pkg::Lanes-1:0]    rem_clr;

	assign busy    = |rem_q;
	assign adv     = !out_valid_q || out_ready;
	assign fire    = busy && adv;
	assign rem_clr = rem_q & (rem_q - 8'd1);
	assign pop     = !empty && (!busy || (fire && (rem_clr == '0)));

	// Lowest set lane.
	always_comb begin
		sel = '0;
		for (int k = blx_pkg::Lanes - 1; k >= 0; k--) begin
			if (rem_q[k]) begin
				sel = blx_pkg::LaneW'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (fire) begin
			index_q <= cur_q.row_base + {10'd0, cur_q.xcol[sel]};
			last_q  <= rem_clr == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= head.mask;
			end else if (fire) begin
				rem_q <= rem_clr;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_index  = index_q;
	assign last_of_byte = last_q;

endmodule

// ===== rtl/bitmap_layer_expand_blit.sv =====
// ----------------------------------------------------------------------------
// bitmap_layer_expand_blit: monochrome layer to colour pixel writes
// Expands a 1-bit-per-pixel layer bitmap, centred in the frame, into
// rounded-colour pixel writes.
// ----------------------------------------------------------------------------
// The layer arrives one byte per input beat, bit 0 leftmost, each row padded
// to whole bytes. Every set bit that lands inside the frame gives one output
// beat carrying the linear frame index and the layer colour rounded to 8 bits
// per channel; last_of_byte marks the final write of a byte. A byte with no
// in-frame writes is absorbed with no output beat, and the intake takes a
// byte every cycle while its two-entry job queue has room. The emitter
// produces one write per cycle while the output is not stalled, up to 8
// writes per byte. A taken byte's job is written into the job queue, loaded
// from there into the emitter and then registered into the output beat.
// Any write to a listed register restarts the layer at its first row and
// column; bytes past the last row are dropped. Write registers only while
// idle.
// ----------------------------------------------------------------------------
module bitmap_layer_expand_blit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  blx_pkg::cfg_idx_t         cfg_index,
	input  logic [blx_pkg::LevelW-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                bitmap_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [blx_pkg::IdxW-1:0]  pixel_index,
	output logic [blx_pkg::ChanW-1:0] red_out,
	output logic [blx_pkg::ChanW-1:0] green_out,
	output logic [blx_pkg::ChanW-1:0] blue_out,
	output logic                      last_of_byte
);

	blx_pkg::dims_t            dims_q;
	logic [blx_pkg::ChanW-1:0] red_q;
	logic [blx_pkg::ChanW-1:0] green_q;
	logic [blx_pkg::ChanW-1:0] blue_q;
	logic [blx_pkg::DimW-1:0]  wdim;
	logic                      restart;
	logic                      push;
	logic                      pop;
	logic                      full;
	logic                      empty;
	blx_pkg::job_t             wr_job;
	blx_pkg::job_t             rd_job;

	// Dimensions are stored already clamped; colours are stored already rounded.
	assign wdim    = blx_pkg::clamp_dim(cfg_wdata[blx_pkg::DimW-1:0]);
	assign restart = cfg_we && (cfg_index inside
		{[blx_pkg::CFG_FRAME_WIDTH:blx_pkg::CFG_BLUE_LEVEL]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.frame_width  <= 11'd640;
			dims_q.frame_height <= 11'd480;
			dims_q.layer_width  <= 11'd8;
			dims_q.layer_height <= 11'd8;
			red_q               <= 8'd255;
			green_q             <= 8'd255;
			blue_q              <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				blx_pkg::CFG_FRAME_WIDTH:  dims_q.frame_width  <= wdim;
				blx_pkg::CFG_FRAME_HEIGHT: dims_q.frame_height <= wdim;
				blx_pkg::CFG_LAYER_WIDTH:  dims_q.layer_width  <= wdim;
				blx_pkg::CFG_LAYER_HEIGHT: dims_q.layer_height <= wdim;
				blx_pkg::CFG_RED_LEVEL:    red_q   <= blx_pkg::round_level(cfg_wdata);
				blx_pkg::CFG_GREEN_LEVEL:  green_q <= blx_pkg::round_level(cfg_wdata);
				blx_pkg::CFG_BLUE_LEVEL:   blue_q  <= blx_pkg::round_level(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	// Intake: classify the byte and queue its writes.
	blx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.dims        (dims_q),
		.restart     (restart),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.bitmap_byte (bitmap_byte),
		.push        (push),
		.job         (wr_job),
		.full        (full)
	);

	blx_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	// Emission: one write beat per cycle while the output is not stalled.
	blx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (rd_job),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_index  (pixel_index),
		.last_of_byte (last_of_byte)
	);

	// User must change colour only while idle (unenforced); fed from registers.
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;

endmodule

// ===== bench/bitmap_layer_expand_blit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_layer_expand_blit_test: self-checking bench for the layer blit
// Streams bitmap bytes through the block under random flow control, predicts
// pixel writes from a bench-side model of the layer walk or takes them from
// typed rows, and checks the output beats in order, field by field.
// ----------------------------------------------------------------------------
module bitmap_layer_expand_blit_test;

	// Index past the register list: a write there must change nothing.
	localparam blx_pkg::cfg_idx_t CFG_SPARE = 3'd7;

	localparam int CycleLimit   = 400000;
	localparam int HoldCycles   = 300;
	localparam int SettleCycles = 8;
	localparam int RandomBytes  = 240;
	localparam int PhaseCap     = 90;
	localparam int DirRows      = 40;

	// One expected pixel write.
	typedef struct packed {
		logic [blx_pkg::IdxW-1:0]  index;
		logic [blx_pkg::ChanW-1:0] red;
		logic [blx_pkg::ChanW-1:0] green;
		logic [blx_pkg::ChanW-1:0] blue;
		logic                      last;
	} pixel_write_t;

	// Directed rows: a register write, a predicted byte, or a byte whose
	// outcome is typed in (no writes, or exactly one write).
	typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_BYTE_NONE, ROW_BYTE_ONE} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		blx_pkg::cfg_idx_t          index;
		logic [blx_pkg::LevelW-1:0] value;
		logic [blx_pkg::IdxW-1:0]   pix;
		logic [blx_pkg::ChanW-1:0]  red;
		logic [blx_pkg::ChanW-1:0]  green;
		logic [blx_pkg::ChanW-1:0]  blue;
	} dir_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	blx_pkg::cfg_idx_t          cfg_index;
	logic [blx_pkg::LevelW-1:0] cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic [7:0]                 bitmap_byte;
	logic                       out_valid;
	logic                       out_ready;
	logic [blx_pkg::IdxW-1:0]   pixel_index;
	logic [blx_pkg::ChanW-1:0]  red_out;
	logic [blx_pkg::ChanW-1:0]  green_out;
	logic [blx_pkg::ChanW-1:0]  blue_out;
	logic                       last_of_byte;

	// Bench copy of the registers and of the layer walk.
	logic [blx_pkg::DimW-1:0]   frame_w, frame_h, layer_w, layer_h;
	logic [blx_pkg::LevelW-1:0] red_lvl, green_lvl, blue_lvl;
	int                         col_base, row_cnt;

	pixel_write_t        expected_writes[$];
	pixel_write_t        byte_writes[$];
	pixel_write_t        head;
	int                  errors = 0;
	int                  cycle_count = 0;
	logic                sender_quiet = 1'b0;
	logic                receiver_quiet = 1'b0;
	logic                hold_req = 1'b0;

	// Reset state is 640x480 frame, 8x8 layer, full white; the typed rows
	// below follow from that by hand.
	dir_row_t dir_rows [DirRows] = '{
		'{ROW_BYTE_ONE,  CFG_SPARE, 16'h0001, 20'd151356, 8'd255, 8'd255, 8'd255},
		'{ROW_BYTE_ONE,  CFG_SPARE, 16'h0080, 20'd152003, 8'd255, 8'd255, 8'd255},
		'{ROW_BYTE_NONE, CFG_SPARE, 16'h0000, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE,      CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		// unlisted index: the layer walk must carry on at row 4
		'{ROW_CFG,       CFG_SPARE, 16'hFFFF, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE,      CFG_SPARE, 16'h005A, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_RED_LEVEL,    16'h0000, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_GREEN_LEVEL,  16'h8000, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_BLUE_LEVEL,   16'h0081, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_ONE,  CFG_SPARE, 16'h0001, 20'd151356, 8'd0, 8'd128, 8'd1},
		// smallest frame and layer; padding bits must be dropped
		'{ROW_CFG, blx_pkg::CFG_FRAME_WIDTH,  16'd1, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_FRAME_HEIGHT, 16'd1, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_LAYER_WIDTH,  16'd1, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_LAYER_HEIGHT, 16'd1, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_ONE,  CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd128, 8'd1},
		'{ROW_BYTE_NONE, CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_LAYER_HEIGHT, 16'd0, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_NONE, CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		// zero layer width: every byte closes a row with no writes
		'{ROW_CFG, blx_pkg::CFG_LAYER_HEIGHT, 16'd2047, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_LAYER_WIDTH,  16'd0, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_NONE, CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_NONE, CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		// oversized everything, clamped to 1024
		'{ROW_CFG, blx_pkg::CFG_FRAME_WIDTH,  16'd2047, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_FRAME_HEIGHT, 16'd2047, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_LAYER_WIDTH,  16'd2047, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_ONE,  CFG_SPARE, 16'h0001, 20'd0, 8'd0, 8'd128, 8'd1},
		'{ROW_BYTE_ONE,  CFG_SPARE, 16'h0080, 20'd15, 8'd0, 8'd128, 8'd1},
		// zero frame dimensions drop everything
		'{ROW_CFG, blx_pkg::CFG_FRAME_WIDTH,  16'd0, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_NONE, CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_FRAME_WIDTH,  16'd8, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_FRAME_HEIGHT, 16'd0, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE_NONE, CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		// layer larger than frame by an odd amount: negative offsets and
		// truncation of -1/2 toward zero
		'{ROW_CFG, blx_pkg::CFG_FRAME_WIDTH,  16'd5, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_FRAME_HEIGHT, 16'd5, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_LAYER_WIDTH,  16'd8, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG, blx_pkg::CFG_LAYER_HEIGHT, 16'd8, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE,      CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE,      CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE,      CFG_SPARE, 16'h00FF, 20'd0, 8'd0, 8'd0, 8'd0},
		'{ROW_BYTE,      CFG_SPARE, 16'h00A5, 20'd0, 8'd0, 8'd0, 8'd0}
	};

	bitmap_layer_expand_blit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.bitmap_byte  (bitmap_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_index  (pixel_index),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.last_of_byte (last_of_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic int clamp_size(input logic [blx_pkg::DimW-1:0] v);
		return (int'(v) > blx_pkg::MaxDim) ? blx_pkg::MaxDim : int'(v);
	endfunction

	function automatic logic [blx_pkg::ChanW-1:0] level_to_chan(
		input logic [blx_pkg::LevelW-1:0] lvl);
		int unsigned t;
		t = (32'(lvl) * 255 + 32767) / 65535;
		return t[blx_pkg::ChanW-1:0];
	endfunction

	// Centre a layer coordinate in the frame; SV integer division
	// truncates toward zero, so -1/2 lands on 0.
	function automatic int centre_coord(input int t, input int lsize, input int fsize);
		return (2 * t - lsize + fsize) / 2;
	endfunction

	function automatic void reset_layer_model();
		frame_w   = 11'd640;
		frame_h   = 11'd480;
		layer_w   = 11'd8;
		layer_h   = 11'd8;
		red_lvl   = 16'hFFFF;
		green_lvl = 16'hFFFF;
		blue_lvl  = 16'hFFFF;
		col_base  = 0;
		row_cnt   = 0;
	endfunction

	function automatic void apply_reg(input blx_pkg::cfg_idx_t idx,
		input logic [blx_pkg::LevelW-1:0] value);
		case (idx)
			blx_pkg::CFG_FRAME_WIDTH: begin
				frame_w = value[blx_pkg::DimW-1:0];
			end
			blx_pkg::CFG_FRAME_HEIGHT: begin
				frame_h = value[blx_pkg::DimW-1:0];
			end
			blx_pkg::CFG_LAYER_WIDTH: begin
				layer_w = value[blx_pkg::DimW-1:0];
			end
			blx_pkg::CFG_LAYER_HEIGHT: begin
				layer_h = value[blx_pkg::DimW-1:0];
			end
			blx_pkg::CFG_RED_LEVEL: begin
				red_lvl = value;
			end
			blx_pkg::CFG_GREEN_LEVEL: begin
				green_lvl = value;
			end
			blx_pkg::CFG_BLUE_LEVEL: begin
				blue_lvl = value;
			end
			default: begin
				return;
			end
		endcase
		// any listed register restarts the layer
		col_base = 0;
		row_cnt  = 0;
	endfunction

	// Expand one byte into byte_writes and advance the layer walk.
	// Returns 0 when the byte falls past the layer and is ignored.
	function automatic logic expand_byte(input logic [7:0] b);
		int           fw, fh, lw, lh, x, y, col;
		pixel_write_t w;
		fw = clamp_size(frame_w);
		fh = clamp_size(frame_h);
		lw = clamp_size(layer_w);
		lh = clamp_size(layer_h);
		byte_writes.delete();
		if (row_cnt >= lh) begin
			return 1'b0;
		end
		y = centre_coord(row_cnt, lh, fh);
		for (int k = 0; k < 8; k++) begin
			col = col_base + k;
			if (col < lw && b[k]) begin
				x = centre_coord(col, lw, fw);
				if (x >= 0 && y >= 0 && x < fw && y < fh) begin
					w.index = blx_pkg::IdxW'(y * fw + x);
					w.red   = level_to_chan(red_lvl);
					w.green = level_to_chan(green_lvl);
					w.blue  = level_to_chan(blue_lvl);
					w.last  = 1'b0;
					byte_writes.push_back(w);
				end
			end
		end
		if (byte_writes.size() > 0) begin
			byte_writes[byte_writes.size() - 1].last = 1'b1;
		end
		col_base += 8;
		if (col_base >= lw) begin
			col_base = 0;
			row_cnt++;
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Drivers (all inputs move on the falling edge)
	// ------------------------------------------------------------------

	// Offer one byte after a random gap, hold it until the beat is taken,
	// then queue what it should produce. Returns on the next falling edge
	// with in_valid still high so back-to-back bytes need no drop.
	task automatic push_byte(input logic [7:0] b, input row_kind_t kind,
		input pixel_write_t typed, output logic used);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		bitmap_byte <= b;
		do @(posedge clk); while (!in_ready);
		used = expand_byte(b);
		case (kind)
			ROW_BYTE_NONE: begin
			end
			ROW_BYTE_ONE: begin
				expected_writes.push_back(typed);
			end
			default: begin
				foreach (byte_writes[i]) expected_writes.push_back(byte_writes[i]);
			end
		endcase
		@(negedge clk);
	endtask

	// Drop valid and let the block drain before touching registers.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_writes.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input blx_pkg::cfg_idx_t idx,
		input logic [blx_pkg::LevelW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [blx_pkg::LevelW-1:0] fw,
		input logic [blx_pkg::LevelW-1:0] fh,
		input logic [blx_pkg::LevelW-1:0] lw, input logic [blx_pkg::LevelW-1:0] lh,
		input logic [blx_pkg::LevelW-1:0] r, input logic [blx_pkg::LevelW-1:0] g,
		input logic [blx_pkg::LevelW-1:0] b);
		write_reg(blx_pkg::CFG_FRAME_WIDTH, fw);
		write_reg(blx_pkg::CFG_FRAME_HEIGHT, fh);
		write_reg(blx_pkg::CFG_LAYER_WIDTH, lw);
		write_reg(blx_pkg::CFG_LAYER_HEIGHT, lh);
		write_reg(blx_pkg::CFG_RED_LEVEL, r);
		write_reg(blx_pkg::CFG_GREEN_LEVEL, g);
		write_reg(blx_pkg::CFG_BLUE_LEVEL, b);
	endtask

	// Random dimension: mostly small, sometimes zero, one, 1024 or
	// oversized; now and then with junk above the 11 register bits.
	function automatic logic [blx_pkg::LevelW-1:0] pick_dim(input int top);
		logic [blx_pkg::LevelW-1:0] v;
		case ($urandom_range(0, 15))
			0: v = 16'd0;
			1: v = 16'd1;
			2: v = 16'd1024;
			3: v = 16'($urandom_range(1025, 2047));
			default: v = 16'($urandom_range(2, top));
		endcase
		if ($urandom_range(0, 3) == 0) begin
			v[blx_pkg::LevelW-1:blx_pkg::DimW] = 5'($urandom);
		end
		return v;
	endfunction

	function automatic logic [blx_pkg::LevelW-1:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return blx_pkg::LevelW'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'hFF;
			1: return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Output side: random back-pressure, one long hold on request
	// ------------------------------------------------------------------
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = 0;
			if (hold_req) begin
				stall = HoldCycles;
			end else if (!receiver_quiet) begin
				stall = $urandom_range(0, 9);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			hold_req = 1'b0;
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Checking: each taken beat against the oldest expected write
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_writes.size() == 0) begin
				$display("%0t: unexpected pixel write, expected none, got index %0d",
					$time, pixel_index);
				errors++;
			end else begin
				head = expected_writes.pop_front();
				check_field("pixel_index", head.index, pixel_index);
				check_field("red_out", head.red, red_out);
				check_field("green_out", head.green, green_out);
				check_field("blue_out", head.blue, blue_out);
				check_field("last_of_byte", head.last, last_of_byte);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d writes outstanding",
				cycle_count, expected_writes.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic         used;
		pixel_write_t typed;
		int           sent, lw, lh, per_row, n;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = blx_pkg::CFG_FRAME_WIDTH;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		bitmap_byte = 8'h00;
		reset_layer_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				settle();
				write_reg(dir_rows[r].index, dir_rows[r].value);
			end else begin
				typed = '{dir_rows[r].pix, dir_rows[r].red, dir_rows[r].green,
					dir_rows[r].blue, 1'b1};
				push_byte(dir_rows[r].value[7:0], dir_rows[r].kind, typed, used);
			end
		end

		// Hold the output off for a long stretch while solid bytes keep
		// coming, so the job queue fills and the intake stalls.
		settle();
		program_regs(16'd128, 16'd128, 16'd64, 16'd4, pick_level(), pick_level(),
			pick_level());
		sender_quiet = 1'b1;
		hold_req     = 1'b1;
		repeat (32) push_byte(8'hFF, ROW_BYTE, '0, used);

		// Random layers: mostly whole, well-formed layers with random
		// bits, plus a few trailing bytes past the last row.
		sent = 0;
		while (sent < RandomBytes) begin
			settle();
			sender_quiet   = ($urandom_range(0, 3) == 0);
			receiver_quiet = ($urandom_range(0, 3) == 0);
			program_regs(pick_dim(64), pick_dim(64), pick_dim(40), pick_dim(12),
				pick_level(), pick_level(), pick_level());
			lw      = clamp_size(layer_w);
			lh      = clamp_size(layer_h);
			per_row = (lw == 0) ? 1 : (lw + 7) / 8;
			n       = (per_row * lh > PhaseCap) ? PhaseCap : per_row * lh;
			n       += $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				// now and then poke the unlisted index mid-layer
				if (i == n / 2 && $urandom_range(0, 5) == 0) begin
					settle();
					write_reg(CFG_SPARE, blx_pkg::LevelW'($urandom));
				end
				push_byte(pick_byte(), ROW_BYTE, '0, used);
				if (used) begin
					sent++;
				end
			end
		end

		settle();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/blx_pkg.sv
rtl/blx_front.sv
rtl/blx_fifo.sv
rtl/blx_back.sv
rtl/bitmap_layer_expand_blit.sv
bench/bitmap_layer_expand_blit_test.sv
